// ===== rtl/ilid_pkg.sv =====
// ============================================================================
// ilid_pkg
// Shared types and codes for the positional list unit.
// ============================================================================
package ilid_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned POS_W  = 9;
    localparam int unsigned LEN_W  = 9;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned STAT_W = 2;

    // request codes
    localparam logic [KIND_W-1:0] REQ_GET      = 3'd0;
    localparam logic [KIND_W-1:0] REQ_INS_HEAD = 3'd1;
    localparam logic [KIND_W-1:0] REQ_INS_TAIL = 3'd2;
    localparam logic [KIND_W-1:0] REQ_INS_POS  = 3'd3;
    localparam logic [KIND_W-1:0] REQ_DEL      = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic        [KIND_W-1:0] req_type;
        logic        [POS_W-1:0]  position;
        logic signed [WORD_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic        [STAT_W-1:0] status;
        logic        [LEN_W-1:0]  length;
    } t_rsp;

endpackage

// ===== rtl/ilid_mem.sv =====
// ============================================================================
// ilid_mem
// Element store: one write port, one read port, registered read data.
// ============================================================================
module ilid_mem
    import ilid_pkg::*;
#(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/indexed_list_insert_delete_unit.sv =====
// ============================================================================
// indexed_list_insert_delete_unit
// Ordered list of signed words with get, insert and delete by position.
// ============================================================================
// Usage:
//   Raise start with a request word on i_req while busy is low; the word is
//   taken at that edge and busy stays high until the result is issued.
//   Each request gives exactly one result word on o_rsp, shown for a single
//   cycle with o_strobe high. The receiver has no way to hold it off.
//   Each request word is first checked in the evaluate state. A rejected
//   request, or a delete of the last element, gives its result from there.
//   A get reads the store and then gives the word it read. An insert moves
//   the words from its position on up by one, from the tail down, then
//   writes the new word and gives its result; a delete moves the words
//   after its position down by one and gives its result with the last move.
//   Elements move one word at a time: the store has one read and one
//   write port, and each moved word is read, then written one place over.
//   busy drops while the result is shown, so the next word can be taken at
//   the edge that ends the strobe cycle.
//   Reset empties the list at once; the store itself is not cleared.
// ============================================================================
module indexed_list_insert_delete_unit
    import ilid_pkg::*;
#(
    parameter int unsigned DEPTH = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_rsp o_rsp
);

    localparam int unsigned AW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_GET,
        S_INS,
        S_INSPUT,
        S_DEL
    } t_state;

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_p, n_p;
    logic              r_strobe, n_strobe;
    t_rsp              r_rsp, n_rsp;

    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [WORD_W-1:0] mem_wd;
    logic [AW-1:0]     mem_ra;
    logic [WORD_W-1:0] mem_rd;

    logic [CMPW-1:0]   pos_x;
    logic [CMPW-1:0]   cnt_x;
    logic [CMPW-1:0]   ins_p_x;
    logic              full;
    logic [AW-1:0]     idx_dec;
    logic [AW-1:0]     idx_inc;

    function automatic t_rsp make_rsp(logic [STAT_W-1:0] st, logic [WORD_W-1:0] rd,
                                      logic [CW-1:0] cnt);
        t_rsp r;
        r.read_value = rd;
        r.status     = st;
        r.length     = LEN_W'(cnt);
        return r;
    endfunction

    ilid_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wa),
        .i_wr_data (mem_wd),
        .i_rd_addr (mem_ra),
        .o_rd_data (mem_rd)
    );

    assign pos_x   = CMPW'(r_req.position);
    assign cnt_x   = CMPW'(r_count);
    assign full    = (r_count == CW'(DEPTH));
    assign idx_dec = r_idx - 1'b1;
    assign idx_inc = r_idx + 1'b1;

    always_comb begin
        case (r_req.req_type)
            REQ_INS_HEAD: ins_p_x = '0;
            REQ_INS_TAIL: ins_p_x = cnt_x;
            default:      ins_p_x = pos_x;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_count  = r_count;
        n_idx    = r_idx;
        n_p      = r_p;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;
        mem_we   = 1'b0;
        mem_wa   = r_idx;
        mem_wd   = mem_rd;
        mem_ra   = r_idx;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = S_EVAL;
                end
            end

            S_EVAL: begin
                case (r_req.req_type)
                    REQ_GET: begin
                        if (pos_x < cnt_x) begin
                            mem_ra  = AW'(r_req.position);
                            n_state = S_GET;
                        end else begin
                            n_strobe = 1'b1;
                            n_rsp    = make_rsp(ST_BADPOS, '1, r_count);
                            n_state  = S_IDLE;
                        end
                    end
                    REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
                        if (ins_p_x > cnt_x) begin
                            n_strobe = 1'b1;
                            n_rsp    = make_rsp(ST_BADPOS, '1, r_count);
                            n_state  = S_IDLE;
                        end else if (full) begin
                            n_strobe = 1'b1;
                            n_rsp    = make_rsp(ST_FULL, '1, r_count);
                            n_state  = S_IDLE;
                        end else begin
                            n_p = AW'(ins_p_x);
                            if (cnt_x > ins_p_x) begin
                                // open a gap: move words up starting at the tail
                                n_idx   = AW'(r_count);
                                mem_ra  = AW'(r_count - 1'b1);
                                n_state = S_INS;
                            end else begin
                                n_state = S_INSPUT;
                            end
                        end
                    end
                    REQ_DEL: begin
                        if (pos_x < cnt_x) begin
                            if (pos_x < cnt_x - 1'b1) begin
                                n_idx   = AW'(r_req.position);
                                mem_ra  = AW'(r_req.position) + 1'b1;
                                n_state = S_DEL;
                            end else begin
                                n_count  = r_count - 1'b1;
                                n_strobe = 1'b1;
                                n_rsp    = make_rsp(ST_OK, '1, r_count - 1'b1);
                                n_state  = S_IDLE;
                            end
                        end else begin
                            n_strobe = 1'b1;
                            n_rsp    = make_rsp(ST_BADPOS, '1, r_count);
                            n_state  = S_IDLE;
                        end
                    end
                    default: begin
                        n_strobe = 1'b1;
                        n_rsp    = make_rsp(ST_BADPOS, '1, r_count);
                        n_state  = S_IDLE;
                    end
                endcase
            end

            S_GET: begin
                n_strobe = 1'b1;
                n_rsp    = make_rsp(ST_OK, mem_rd, r_count);
                n_state  = S_IDLE;
            end

            S_INS: begin
                mem_we = 1'b1;
                if (r_idx == r_p + 1'b1) begin
                    n_state = S_INSPUT;
                end else begin
                    n_idx  = idx_dec;
                    mem_ra = idx_dec - 1'b1;
                end
            end

            S_INSPUT: begin
                mem_we   = 1'b1;
                mem_wa   = r_p;
                mem_wd   = r_req.value;
                n_count  = r_count + 1'b1;
                n_strobe = 1'b1;
                n_rsp    = make_rsp(ST_OK, '1, r_count + 1'b1);
                n_state  = S_IDLE;
            end

            S_DEL: begin
                mem_we = 1'b1;
                if (CW'(r_idx) + CW'(2) == r_count) begin
                    n_count  = r_count - 1'b1;
                    n_strobe = 1'b1;
                    n_rsp    = make_rsp(ST_OK, '1, r_count - 1'b1);
                    n_state  = S_IDLE;
                end else begin
                    n_idx  = idx_inc;
                    mem_ra = idx_inc + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_req <= n_req;
        r_idx <= n_idx;
        r_p   <= n_p;
        r_rsp <= n_rsp;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list length exceeds capacity");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_rsp.status == ST_FULL |-> o_rsp.length == LEN_W'(DEPTH))
        else $error("full status with list not full");

    a_fail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_rsp.status != ST_OK |-> o_rsp.read_value == '1)
        else $error("failed request carries a read value");

    a_move_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS || r_state == S_DEL) && n_state == r_state |-> mem_wa != mem_ra)
        else $error("shift reads the entry it writes");

endmodule
